// ===== hdl/tllw_pkg.sv =====
// Shared types, constants and saturation helpers of the text line layout walker.
// Used by every other file of the block; depends on nothing.
`timescale 1ns / 1ps

package tllw_pkg;

  localparam int CP_W       = 21;
  localparam int ADV_W      = 16;
  localparam int TAB_W      = 18;
  localparam int XY_W       = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CP_W-1:0] CP_TAB   = 21'd9;
  localparam logic [CP_W-1:0] CP_LF    = 21'd10;
  localparam logic [CP_W-1:0] CP_CR    = 21'd13;
  localparam logic [CP_W-1:0] CP_SPACE = 21'd32;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_ADVANCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_ADVANCE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_WIDTH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_SPACING = 3'd7;

  localparam logic [15:0] RST_LINE_ADVANCE = 16'd4096;
  localparam logic [15:0] RST_LINE_HEIGHT  = 16'd4096;
  localparam logic [17:0] RST_TAB_ADVANCE  = 18'd12288;
  localparam logic [15:0] RST_SCALE        = 16'd256;

  localparam logic RK_PLACE   = 1'b0;
  localparam logic RK_MEASURE = 1'b1;

  typedef enum logic [2:0] {
    K_SKIP    = 3'd0,
    K_NEWLINE = 3'd1,
    K_TAB     = 3'd2,
    K_MISSING = 3'd3,
    K_GLYPH   = 3'd4
  } item_kind_e;

  // One classified request as it waits between the front and the back part.
  typedef struct packed {
    item_kind_e         kind;
    logic               is_space;
    logic               cp_nonzero;
    logic [ADV_W-1:0]   glyph_advance;
    logic signed [15:0] pair_kerning;
    logic               end_of_text;
  } entry_t;

  typedef struct packed {
    logic [15:0]        line_advance;
    logic [15:0]        line_height;
    logic [TAB_W-1:0]   tab_advance;
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic [23:0]        wrap_width;
    logic [23:0]        max_height;
    logic signed [15:0] letter_spacing;
  } cfg_t;

  typedef struct packed {
    logic                 result_kind;
    logic signed [XY_W-1:0] pen_x;
    logic [XY_W-1:0]      pen_y;
    logic [XY_W-1:0]      measured_width;
    logic [XY_W-1:0]      measured_height;
    logic                 last_of_run;
  } out_item_t;

  function automatic logic signed [31:0] sat_s32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] sat_u32(input logic signed [34:0] v);
    if (v < 35'sd0) begin
      return 32'd0;
    end else if (v > 35'sd4294967295) begin
      return 32'hFFFF_FFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic [XY_W-1:0] sat_s24(input logic signed [31:0] v);
    if (v > 32'sd8388607) begin
      return 24'h7F_FFFF;
    end else if (v < -32'sd8388608) begin
      return 24'h80_0000;
    end
    return v[23:0];
  endfunction

  function automatic logic [XY_W-1:0] sat_u24(input logic [43:0] v);
    return (v > 44'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
  endfunction

endpackage

// ===== hdl/tllw_intf.sv =====
// Valid/ready channel interfaces for codepoint requests and layout results.
// Depends on tllw_pkg for the field widths.
`timescale 1ns / 1ps

interface tllw_item_if;
  logic                        valid;
  logic                        ready;
  logic [tllw_pkg::CP_W-1:0]   code_point;
  logic                        glyph_found;
  logic [tllw_pkg::ADV_W-1:0]  glyph_advance;
  logic signed [15:0]          pair_kerning;
  logic                        end_of_text;

  modport source (
    output valid, code_point, glyph_found, glyph_advance, pair_kerning, end_of_text,
    input  ready
  );
  modport sink (
    input  valid, code_point, glyph_found, glyph_advance, pair_kerning, end_of_text,
    output ready
  );
endinterface

interface tllw_result_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic signed [tllw_pkg::XY_W-1:0] pen_x;
  logic [tllw_pkg::XY_W-1:0]     pen_y;
  logic [tllw_pkg::XY_W-1:0]     measured_width;
  logic [tllw_pkg::XY_W-1:0]     measured_height;
  logic                          last_of_run;

  modport source (
    output valid, result_kind, pen_x, pen_y, measured_width, measured_height, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, result_kind, pen_x, pen_y, measured_width, measured_height, last_of_run,
    output ready
  );
endinterface

// ===== hdl/text_line_layout_walker.sv =====
// Top level of the text line layout walker: configuration registers and the
// front, queue and back parts. Depends on tllw_pkg, tllw_intf.sv and the tllw_* modules.
//
//   channel    direction  accepted when           carries
//   item_i     in         valid && ready          one decoded codepoint request
//   result_o   out        valid && ready          glyph placement or measurement
//   cfg_*      in         cfg_we_i high           register write, no read-back
//
// The front takes one request per cycle while the queue has room.
// The back takes a request in ST_PROD, where the wrap and height products are
// registered, then compares them in ST_PLACE and updates the pen cursor; this cursor loop
// through the multipliers means it takes no new request until the last one has left ST_PLACE.
// A request with end_of_text then goes through ST_MPROD for the measurement products.
// Reset clears the cursor, the queue and the result valid flag and loads the
// register defaults; a stalled result only stops the back, the queue keeps filling.
`timescale 1ns / 1ps

module text_line_layout_walker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tllw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tllw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  tllw_item_if.sink                          item_i,
  tllw_result_if.source                      result_o
);

  tllw_pkg::cfg_t   cfg_q;
  logic             push_valid, push_ready;
  tllw_pkg::entry_t push_entry;
  logic             q_valid, q_pop;
  tllw_pkg::entry_t q_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_advance   <= tllw_pkg::RST_LINE_ADVANCE;
      cfg_q.line_height    <= tllw_pkg::RST_LINE_HEIGHT;
      cfg_q.tab_advance    <= tllw_pkg::RST_TAB_ADVANCE;
      cfg_q.scale_x        <= tllw_pkg::RST_SCALE;
      cfg_q.scale_y        <= tllw_pkg::RST_SCALE;
      cfg_q.wrap_width     <= '0;
      cfg_q.max_height     <= '0;
      cfg_q.letter_spacing <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tllw_pkg::REG_LINE_ADVANCE:   cfg_q.line_advance   <= cfg_data_i[15:0];
        tllw_pkg::REG_LINE_HEIGHT:    cfg_q.line_height    <= cfg_data_i[15:0];
        tllw_pkg::REG_TAB_ADVANCE:    cfg_q.tab_advance    <= cfg_data_i[17:0];
        tllw_pkg::REG_SCALE_X:        cfg_q.scale_x        <= cfg_data_i[15:0];
        tllw_pkg::REG_SCALE_Y:        cfg_q.scale_y        <= cfg_data_i[15:0];
        tllw_pkg::REG_WRAP_WIDTH:     cfg_q.wrap_width     <= cfg_data_i[23:0];
        tllw_pkg::REG_MAX_HEIGHT:     cfg_q.max_height     <= cfg_data_i[23:0];
        tllw_pkg::REG_LETTER_SPACING: cfg_q.letter_spacing <= $signed(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  tllw_front u_front (
    .item_i       (item_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  tllw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_i        (q_pop),
    .pop_valid_o  (q_valid),
    .pop_entry_o  (q_entry)
  );

  tllw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .result_o  (result_o)
  );

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back part popped an empty queue");

  a_measure_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.result_kind == tllw_pkg::RK_MEASURE)) |->
      (result_o.last_of_run && (result_o.pen_x == '0) && (result_o.pen_y == '0)))
    else $error("measurement result is malformed");

  a_place_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.result_kind == tllw_pkg::RK_PLACE)) |->
      ((result_o.measured_width == '0) && (result_o.measured_height == '0)))
    else $error("placement result carries measurement data");

endmodule

// ===== hdl/tllw_front.sv =====
// Front part: accepts codepoint requests and classifies them for the queue.
// Depends on tllw_pkg and the item interface in tllw_intf.sv.
`timescale 1ns / 1ps

module tllw_front (
  tllw_item_if.sink        item_i,
  output logic             push_valid_o,
  output tllw_pkg::entry_t push_entry_o,
  input  logic             push_ready_i
);

  tllw_pkg::item_kind_e kind;

  always_comb begin
    if (item_i.code_point == tllw_pkg::CP_CR) begin
      kind = tllw_pkg::K_SKIP;
    end else if (item_i.code_point == tllw_pkg::CP_LF) begin
      kind = tllw_pkg::K_NEWLINE;
    end else if (item_i.code_point == tllw_pkg::CP_TAB) begin
      kind = tllw_pkg::K_TAB;
    end else if (!item_i.glyph_found) begin
      kind = tllw_pkg::K_MISSING;
    end else begin
      kind = tllw_pkg::K_GLYPH;
    end
  end

  assign push_entry_o.kind          = kind;
  assign push_entry_o.is_space      = (item_i.code_point == tllw_pkg::CP_SPACE);
  assign push_entry_o.cp_nonzero    = (item_i.code_point != '0);
  assign push_entry_o.glyph_advance = item_i.glyph_advance;
  assign push_entry_o.pair_kerning  = item_i.pair_kerning;
  assign push_entry_o.end_of_text   = item_i.end_of_text;

  assign push_valid_o = item_i.valid;
  assign item_i.ready = push_ready_i;

endmodule

// ===== hdl/tllw_queue.sv =====
// Short FIFO of classified requests between the front and the back part.
// Depends on tllw_pkg for the entry type.
`timescale 1ns / 1ps

module tllw_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  tllw_pkg::entry_t push_entry_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output tllw_pkg::entry_t pop_entry_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tllw_pkg::entry_t   slots_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== hdl/tllw_back.sv =====
// Back part: pen cursor, wrap and height tests, measurement and the result register.
// Depends on tllw_pkg and the result interface in tllw_intf.sv.
`timescale 1ns / 1ps

module tllw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tllw_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  input  tllw_pkg::entry_t q_entry_i,
  output logic             q_pop_o,
  tllw_result_if.source    result_o
);

  typedef enum logic [3:0] {
    ST_PROD  = 4'b0001,
    ST_PLACE = 4'b0010,
    ST_MPROD = 4'b0100,
    ST_MEAS  = 4'b1000
  } back_state_e;

  back_state_e         state_q, state_d;
  tllw_pkg::entry_t    cur_q;
  logic signed [31:0]  pen_col_q, pen_col_d;
  logic [31:0]         pen_row_q, pen_row_d;
  logic                prior_set_q, prior_set_d;
  logic [31:0]         widest_q, widest_d;
  logic                halted_q, halted_d;
  logic signed [51:0]  prod_w_q;
  logic [48:0]         prod_h_q;
  logic [31:0]         row_brk_q;
  tllw_pkg::out_item_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [17:0]         adv_eff;
  logic [32:0]         row_sum;
  logic [31:0]         row_brk;
  logic                meas_sel;
  logic signed [34:0]  mul_a_op;
  logic signed [51:0]  mul_a;
  logic [32:0]         mul_b_op;
  logic [48:0]         mul_b;
  logic                load_prod;

  logic                wrap_hit, height_hit, place, slot_free;
  logic signed [31:0]  base_col, kern_col;
  logic signed [34:0]  ext, tab_sum;
  logic [31:0]         ext_u;

  // Operand products for the next request (or for the measurement) are
  // registered before any compare uses them.
  assign adv_eff  = (q_entry_i.kind == tllw_pkg::K_TAB) ? cfg_i.tab_advance
                                                        : {2'b0, q_entry_i.glyph_advance};
  assign row_sum  = {1'b0, pen_row_q} + {17'b0, cfg_i.line_advance};
  assign row_brk  = row_sum[32] ? 32'hFFFF_FFFF : row_sum[31:0];
  assign meas_sel = (state_q == ST_MPROD);
  assign mul_a_op = meas_sel ? $signed({3'b0, widest_q})
                             : 35'(pen_col_q) + $signed({17'b0, adv_eff});
  assign mul_b_op = meas_sel ? {1'b0, pen_row_q} + {17'b0, cfg_i.line_height}
                             : {1'b0, row_brk} + {17'b0, cfg_i.line_advance};
  assign mul_a    = mul_a_op * $signed({1'b0, cfg_i.scale_x});
  assign mul_b    = mul_b_op * cfg_i.scale_y;
  assign load_prod = ((state_q == ST_PROD) && q_valid_i) || meas_sel;

  assign wrap_hit   = (cfg_i.wrap_width != '0) && (pen_col_q > 32'sd0) &&
                      (prod_w_q > $signed({20'b0, cfg_i.wrap_width, 8'b0}));
  assign height_hit = (cfg_i.max_height != '0) &&
                      (prod_h_q > {17'b0, cfg_i.max_height, 8'b0});

  // After a wrap the line starts over at zero with no kerning history.
  assign base_col = wrap_hit ? 32'sd0 : pen_col_q;
  assign kern_col = (prior_set_q && !wrap_hit)
                    ? tllw_pkg::sat_s32(35'(base_col) + 35'($signed(cur_q.pair_kerning)))
                    : base_col;
  assign ext      = 35'(kern_col) + $signed({19'b0, cur_q.glyph_advance}) +
                    35'($signed(cfg_i.letter_spacing));
  assign ext_u    = tllw_pkg::sat_u32(ext);
  assign tab_sum  = 35'(base_col) + $signed({17'b0, cfg_i.tab_advance});

  // A space that forces a wrap is dropped, and nothing is placed once halted.
  assign place = !halted_q && (cur_q.kind == tllw_pkg::K_GLYPH) &&
                 !(wrap_hit && (height_hit || cur_q.is_space));

  assign slot_free = !out_valid_q || result_o.ready;

  always_comb begin
    state_d     = state_q;
    pen_col_d   = pen_col_q;
    pen_row_d   = pen_row_q;
    prior_set_d = prior_set_q;
    widest_d    = widest_q;
    halted_d    = halted_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !result_o.ready;
    q_pop_o     = 1'b0;

    unique case (state_q)
      ST_PROD: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (!place || slot_free) begin
          if (!halted_q) begin
            case (cur_q.kind)
              tllw_pkg::K_NEWLINE: begin
                pen_col_d   = 32'sd0;
                pen_row_d   = row_brk_q;
                prior_set_d = 1'b0;
                halted_d    = height_hit;
              end
              tllw_pkg::K_TAB: begin
                if (wrap_hit) begin
                  pen_row_d = row_brk_q;
                end
                if (wrap_hit && height_hit) begin
                  pen_col_d = 32'sd0;
                  halted_d  = 1'b1;
                end else begin
                  pen_col_d = tllw_pkg::sat_s32(tab_sum);
                end
                prior_set_d = 1'b0;
              end
              tllw_pkg::K_MISSING: begin
                prior_set_d = 1'b0;
              end
              tllw_pkg::K_GLYPH: begin
                if (wrap_hit) begin
                  pen_col_d   = 32'sd0;
                  pen_row_d   = row_brk_q;
                  prior_set_d = 1'b0;
                  halted_d    = height_hit;
                end
                if (place) begin
                  pen_col_d   = tllw_pkg::sat_s32(ext);
                  prior_set_d = cur_q.cp_nonzero;
                  if (ext_u > widest_q) begin
                    widest_d = ext_u;
                  end
                  out_valid_d           = 1'b1;
                  out_d.result_kind     = tllw_pkg::RK_PLACE;
                  out_d.pen_x           = tllw_pkg::sat_s24(kern_col);
                  out_d.pen_y           = tllw_pkg::sat_u24({12'b0,
                                            (wrap_hit ? row_brk_q : pen_row_q)});
                  out_d.measured_width  = '0;
                  out_d.measured_height = '0;
                  out_d.last_of_run     = !cur_q.end_of_text;
                end
              end
              default: ;
            endcase
          end
          state_d = cur_q.end_of_text ? ST_MPROD : ST_PROD;
        end
      end
      ST_MPROD: begin
        state_d = ST_MEAS;
      end
      ST_MEAS: begin
        if (slot_free) begin
          out_valid_d           = 1'b1;
          out_d.result_kind     = tllw_pkg::RK_MEASURE;
          out_d.pen_x           = '0;
          out_d.pen_y           = '0;
          out_d.measured_width  = tllw_pkg::sat_u24(prod_w_q[51:8]);
          out_d.measured_height = tllw_pkg::sat_u24({3'b0, prod_h_q[48:8]});
          out_d.last_of_run     = 1'b1;
          pen_col_d   = 32'sd0;
          pen_row_d   = '0;
          prior_set_d = 1'b0;
          widest_d    = '0;
          halted_d    = 1'b0;
          state_d     = ST_PROD;
        end
      end
      default: begin
        state_d = ST_PROD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PROD;
      pen_col_q   <= 32'sd0;
      pen_row_q   <= '0;
      prior_set_q <= 1'b0;
      widest_q    <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pen_col_q   <= pen_col_d;
      pen_row_q   <= pen_row_d;
      prior_set_q <= prior_set_d;
      widest_q    <= widest_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (q_pop_o) begin
      cur_q     <= q_entry_i;
      row_brk_q <= row_brk;
    end
    if (load_prod) begin
      prod_w_q <= mul_a;
      prod_h_q <= mul_b;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.result_kind     = out_q.result_kind;
  assign result_o.pen_x           = out_q.pen_x;
  assign result_o.pen_y           = out_q.pen_y;
  assign result_o.measured_width  = out_q.measured_width;
  assign result_o.measured_height = out_q.measured_height;
  assign result_o.last_of_run     = out_q.last_of_run;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the text line layout walker: a cursor predictor
// with a result scoreboard, driven by directed strings and random strings.
// Depends on tllw_pkg, the channel interfaces in tllw_intf.sv and the block itself.
`timescale 1ns / 1ps

localparam longint S32_MAX = 64'sd2147483647;
localparam longint S32_MIN = -64'sd2147483648;
localparam longint U32_MAX = 64'sd4294967295;
localparam longint S24_MAX = 64'sd8388607;
localparam longint S24_MIN = -64'sd8388608;
localparam longint U24_MAX = 64'sd16777215;

typedef struct packed {
  logic [tllw_pkg::CP_W-1:0]  code_point;
  logic                       glyph_found;
  logic [tllw_pkg::ADV_W-1:0] glyph_advance;
  logic signed [15:0]         pair_kerning;
  logic                       end_of_text;
} request_t;

class layout_scoreboard;
  longint line_advance, line_height, tab_advance, scale_x, scale_y;
  longint wrap_width, max_height, letter_spacing;
  longint pen_column, pen_row, widest_extent;
  logic [tllw_pkg::CP_W-1:0] prior_code;
  bit halted;
  tllw_pkg::out_item_t pending[$];
  int unsigned errors;

  function new();
    line_advance = tllw_pkg::RST_LINE_ADVANCE;
    line_height = tllw_pkg::RST_LINE_HEIGHT;
    tab_advance = tllw_pkg::RST_TAB_ADVANCE;
    scale_x = tllw_pkg::RST_SCALE;
    scale_y = tllw_pkg::RST_SCALE;
    wrap_width = 0;
    max_height = 0;
    letter_spacing = 0;
    errors = 0;
    clear_string();
  endfunction

  function void clear_string();
    pen_column = 0;
    pen_row = 0;
    prior_code = '0;
    widest_extent = 0;
    halted = 1'b0;
  endfunction

  function longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function void write_reg(logic [tllw_pkg::CFG_IDX_W-1:0] index,
                          logic [tllw_pkg::CFG_DATA_W-1:0] value);
    case (index)
      tllw_pkg::REG_LINE_ADVANCE:   line_advance = value[15:0];
      tllw_pkg::REG_LINE_HEIGHT:    line_height = value[15:0];
      tllw_pkg::REG_TAB_ADVANCE:    tab_advance = value[tllw_pkg::TAB_W-1:0];
      tllw_pkg::REG_SCALE_X:        scale_x = value[15:0];
      tllw_pkg::REG_SCALE_Y:        scale_y = value[15:0];
      tllw_pkg::REG_WRAP_WIDTH:     wrap_width = value[23:0];
      tllw_pkg::REG_MAX_HEIGHT:     max_height = value[23:0];
      tllw_pkg::REG_LETTER_SPACING: letter_spacing = $signed(value[15:0]);
      default: ;
    endcase
  endfunction

  // Moves to the next line; returns 1 when that line would pass the height limit.
  function bit break_line();
    pen_column = 0;
    pen_row = clamp(pen_row + line_advance, 0, U32_MAX);
    prior_code = '0;
    return (max_height != 0) && ((pen_row + line_advance) * scale_y > (max_height << 8));
  endfunction

  function bit wrap_due(longint step);
    if (wrap_width == 0 || pen_column <= 0) begin
      return 1'b0;
    end
    return (pen_column + step) * scale_x > (wrap_width << 8);
  endfunction

  function void note_request(request_t r);
    longint advance, kern, ext;
    bit drop, stop, placed;
    tllw_pkg::out_item_t place, measure;
    advance = r.glyph_advance;
    kern = $signed(r.pair_kerning);
    placed = 1'b0;
    place = '0;
    measure = '0;
    if (!halted) begin
      if (r.code_point == tllw_pkg::CP_CR) begin
        // Carriage return leaves everything as it is.
      end else if (r.code_point == tllw_pkg::CP_LF) begin
        if (break_line()) halted = 1'b1;
      end else if (r.code_point == tllw_pkg::CP_TAB) begin
        stop = wrap_due(tab_advance) ? break_line() : 1'b0;
        if (stop) begin
          halted = 1'b1;
        end else begin
          pen_column = clamp(pen_column + tab_advance, S32_MIN, S32_MAX);
          prior_code = '0;
        end
      end else if (!r.glyph_found) begin
        prior_code = '0;
      end else begin
        drop = 1'b0;
        if (wrap_due(advance)) begin
          if (break_line()) halted = 1'b1;
          else if (r.code_point == tllw_pkg::CP_SPACE) drop = 1'b1;
        end
        if (!halted && !drop) begin
          if (prior_code != '0) pen_column = clamp(pen_column + kern, S32_MIN, S32_MAX);
          place.result_kind = tllw_pkg::RK_PLACE;
          place.pen_x = 24'(clamp(pen_column, S24_MIN, S24_MAX));
          place.pen_y = 24'(clamp(pen_row, 0, U24_MAX));
          placed = 1'b1;
          ext = pen_column + advance + letter_spacing;
          if (clamp(ext, 0, U32_MAX) > widest_extent) widest_extent = clamp(ext, 0, U32_MAX);
          pen_column = clamp(ext, S32_MIN, S32_MAX);
          prior_code = r.code_point;
        end
      end
    end
    if (r.end_of_text) begin
      measure.result_kind = tllw_pkg::RK_MEASURE;
      measure.measured_width = 24'(clamp((widest_extent * scale_x) >>> 8, 0, U24_MAX));
      measure.measured_height =
        24'(clamp(((pen_row + line_height) * scale_y) >>> 8, 0, U24_MAX));
      measure.last_of_run = 1'b1;
      clear_string();
    end else if (placed) begin
      place.last_of_run = 1'b1;
    end
    if (placed) pending = {pending, place};
    if (r.end_of_text) pending = {pending, measure};
  endfunction

  function void compare(string field, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h, got %h", $time, field, want, got);
      errors++;
    end
  endfunction

  function void check_result(tllw_pkg::out_item_t got);
    tllw_pkg::out_item_t want;
    if (pending.size() == 0) begin
      $display("%0t unexpected result: expected none, got kind %0d x %h y %h w %h h %h",
               $time, got.result_kind, got.pen_x, got.pen_y, got.measured_width,
               got.measured_height);
      errors++;
      return;
    end
    want = pending.pop_front();
    compare("result_kind", want.result_kind, got.result_kind);
    compare("pen_x", want.pen_x, got.pen_x);
    compare("pen_y", want.pen_y, got.pen_y);
    compare("measured_width", want.measured_width, got.measured_width);
    compare("measured_height", want.measured_height, got.measured_height);
    compare("last_of_run", want.last_of_run, got.last_of_run);
  endfunction
endclass

module testbench;

  localparam int unsigned IDLE_PCT = 19;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int OVERFLOW_TABS = 40;
  localparam int OVERFLOW_LINES = 260;
  localparam int SETTLE_CYCLES = 16;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [tllw_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [tllw_pkg::CFG_DATA_W-1:0] cfg_data_i;

  tllw_item_if item_bus ();
  tllw_result_if result_bus ();

  layout_scoreboard board;
  int unsigned idle_pct;
  longint cycle_count = 0;

  text_line_layout_walker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_bus),
    .result_o    (result_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin : result_sink
    tllw_pkg::out_item_t seen;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      seen.result_kind = result_bus.result_kind;
      seen.pen_x = result_bus.pen_x;
      seen.pen_y = result_bus.pen_y;
      seen.measured_width = result_bus.measured_width;
      seen.measured_height = result_bus.measured_height;
      seen.last_of_run = result_bus.last_of_run;
      board.check_result(seen);
    end
    result_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  function automatic request_t make_request(logic [tllw_pkg::CP_W-1:0] cp, logic found,
                                            logic [15:0] advance, logic [15:0] kern,
                                            logic last);
    request_t r;
    r.code_point = cp;
    r.glyph_found = found;
    r.glyph_advance = advance;
    r.pair_kerning = kern;
    r.end_of_text = last;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.end_of_text = 1'b0;
    r.glyph_found = 1'b1;
    r.glyph_advance = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(256, 4096));
    r.pair_kerning = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 512) - 256);
    if (pick < 50) begin
      r.code_point = 21'($urandom_range(33, 126));
    end else if (pick < 58) begin
      r.code_point = 21'($urandom_range(127, 21'h10FFFF));
    end else if (pick < 68) begin
      r.code_point = tllw_pkg::CP_SPACE;
    end else if (pick < 75) begin
      r.code_point = tllw_pkg::CP_TAB;
    end else if (pick < 81) begin
      r.code_point = tllw_pkg::CP_LF;
    end else if (pick < 85) begin
      r.code_point = tllw_pkg::CP_CR;
    end else if (pick < 92) begin
      r.code_point = 21'($urandom_range(0, 21'h10FFFF));
      r.glyph_found = 1'b0;
    end else begin
      // Noise: any field value, with small codepoints favored to hit the controls.
      r.code_point = ($urandom_range(0, 1) == 0) ? 21'($urandom_range(0, 40))
                                                : 21'($urandom_range(0, 21'h10FFFF));
      r.glyph_found = 1'($urandom_range(0, 1));
      r.glyph_advance = 16'($urandom);
      r.pair_kerning = 16'($urandom);
    end
    return r;
  endfunction

  task automatic send_request(input request_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_bus.valid <= 1'b1;
    item_bus.code_point <= r.code_point;
    item_bus.glyph_found <= r.glyph_found;
    item_bus.glyph_advance <= r.glyph_advance;
    item_bus.pair_kerning <= r.pair_kerning;
    item_bus.end_of_text <= r.end_of_text;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    board.note_request(r);
  endtask

  // Sends whole strings, each closed by an end_of_text request.
  task automatic run_strings(input int count);
    int sent;
    int len;
    request_t r;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        r = random_request();
        r.end_of_text = (i == len - 1);
        send_request(r);
        sent++;
      end
    end
  endtask

  task automatic settle();
    item_bus.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tllw_pkg::CFG_IDX_W-1:0] index,
                           input logic [tllw_pkg::CFG_DATA_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    board.write_reg(index, value);
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [23:0] line_adv, line_hgt, tab_adv, sx, sy,
                              wrap_w, max_h, spacing);
    write_reg(tllw_pkg::REG_LINE_ADVANCE, line_adv);
    write_reg(tllw_pkg::REG_LINE_HEIGHT, line_hgt);
    write_reg(tllw_pkg::REG_TAB_ADVANCE, tab_adv);
    write_reg(tllw_pkg::REG_SCALE_X, sx);
    write_reg(tllw_pkg::REG_SCALE_Y, sy);
    write_reg(tllw_pkg::REG_WRAP_WIDTH, wrap_w);
    write_reg(tllw_pkg::REG_MAX_HEIGHT, max_h);
    write_reg(tllw_pkg::REG_LETTER_SPACING, spacing);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    board = new();
    idle_pct = IDLE_PCT;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    item_bus.valid = 1'b0;
    item_bus.code_point = '0;
    item_bus.glyph_found = 1'b0;
    item_bus.glyph_advance = '0;
    item_bus.pair_kerning = '0;
    item_bus.end_of_text = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: kerning history, controls, missing glyphs, field extremes.
    send_request(make_request(21'd65, 1'b1, 16'h0800, 16'h7FFF, 1'b0));
    send_request(make_request(21'd66, 1'b1, 16'hFFFF, 16'h8000, 1'b0));
    send_request(make_request(tllw_pkg::CP_CR, 1'b1, 16'hFFFF, 16'h7FFF, 1'b0));
    send_request(make_request(tllw_pkg::CP_TAB, 1'b0, 16'h0000, 16'h0000, 1'b0));
    send_request(make_request(21'd67, 1'b1, 16'h0400, 16'h0100, 1'b0));
    send_request(make_request(21'd68, 1'b0, 16'h0400, 16'h0100, 1'b0));
    send_request(make_request(21'd69, 1'b1, 16'h0400, 16'h0100, 1'b0));
    send_request(make_request(21'd70, 1'b1, 16'h0000, 16'hFF00, 1'b0));
    send_request(make_request(tllw_pkg::CP_LF, 1'b1, 16'h0400, 16'h0000, 1'b0));
    send_request(make_request(21'h10FFFF, 1'b1, 16'h0000, 16'h1234, 1'b0));
    send_request(make_request(21'd0, 1'b1, 16'h0300, 16'h4321, 1'b0));
    send_request(make_request(21'd71, 1'b1, 16'h0300, 16'h7FFF, 1'b0));
    send_request(make_request(tllw_pkg::CP_SPACE, 1'b1, 16'h0400, 16'h0000, 1'b1));
    settle();

    // Narrow wrap and a three-line height limit: a wrapped glyph, a dropped
    // space, a tab that wraps into the limit, then a string that runs left.
    apply_config(24'd4096, 24'd2048, 24'd4096, 24'd256, 24'd256, 24'd6000, 24'd12288,
                 24'h00FF00);
    send_request(make_request(21'd65, 1'b1, 16'd2560, 16'h0000, 1'b0));
    send_request(make_request(21'd66, 1'b1, 16'd2560, 16'h0000, 1'b0));
    send_request(make_request(21'd67, 1'b1, 16'd2560, 16'h0000, 1'b0));
    send_request(make_request(tllw_pkg::CP_SPACE, 1'b1, 16'd4096, 16'h0000, 1'b0));
    send_request(make_request(tllw_pkg::CP_TAB, 1'b1, 16'd0, 16'h0000, 1'b0));
    send_request(make_request(tllw_pkg::CP_TAB, 1'b1, 16'd0, 16'h0000, 1'b0));
    send_request(make_request(21'd68, 1'b1, 16'd2560, 16'h0000, 1'b0));
    send_request(make_request(21'd69, 1'b1, 16'd2560, 16'h0000, 1'b1));
    send_request(make_request(21'd65, 1'b1, 16'd0, 16'h0000, 1'b0));
    send_request(make_request(21'd66, 1'b1, 16'h0100, 16'h8000, 1'b0));
    send_request(make_request(tllw_pkg::CP_LF, 1'b1, 16'd0, 16'h0000, 1'b0));
    send_request(make_request(tllw_pkg::CP_CR, 1'b0, 16'd0, 16'h0000, 1'b1));
    settle();

    // One long string that drives the pen column and then the pen row past
    // the 24-bit output range, with every output clamped on the way.
    apply_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0,
                 24'h007FFF);
    for (int i = 0; i < OVERFLOW_TABS; i++) begin
      send_request(make_request(tllw_pkg::CP_TAB, 1'b1, 16'd0, 16'h0000, 1'b0));
    end
    send_request(make_request(21'd65, 1'b1, 16'hFFFF, 16'h7FFF, 1'b0));
    for (int i = 0; i < OVERFLOW_LINES; i++) begin
      send_request(make_request(tllw_pkg::CP_LF, 1'b1, 16'd0, 16'h0000, 1'b0));
    end
    send_request(make_request(21'd66, 1'b1, 16'hFFFF, 16'h0000, 1'b1));
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_pct = (p == 5) ? 0 : IDLE_PCT;
      case (p)
        1: apply_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                        24'hFFFFFF, 24'hFFFFFF, 24'h007FFF);
        2: apply_config(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'h008000);
        default: apply_config(
          {8'($urandom), 16'($urandom_range(1024, 8192))},
          {8'($urandom), 16'($urandom_range(1024, 8192))},
          ($urandom_range(0, 4) == 0) ? 24'($urandom)
                                      : {6'($urandom), 18'($urandom_range(0, 20000))},
          {8'($urandom), 16'($urandom_range(64, 768))},
          {8'($urandom), 16'($urandom_range(64, 768))},
          ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(4000, 80000)),
          ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(10000, 80000)),
          {8'($urandom), 16'($urandom_range(0, 768) - 384)});
      endcase
      run_strings(ITEMS_PER_PHASE);
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
